// File: src/frame_bitmap_allocator_unit_macros.svh
// Assertion macros for the frame bitmap allocator.
`ifndef FRAME_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define FRAME_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define FBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FBA_ASSERT(lbl, prop, msg)
`define FBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: src/fba_pkg.sv
package fba_pkg;

  localparam int unsigned MAX_FRAMES_DEF = 4096;
  localparam int unsigned WORD_BITS      = 32;
  localparam int unsigned WORD_SHIFT     = 5;
  localparam int unsigned CNT_W          = 13;
  localparam int unsigned FRAME_W        = 12;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned ADDR_W         = 3;

  localparam logic [CNT_W-1:0] FRAME_COUNT_RST = 13'd4096;
  localparam logic             REG_FRAME_COUNT = 1'b0;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_HELD      = 3'd1,
    ST_FREED     = 3'd2,
    ST_NOTHING   = 3'd3,
    ST_EXHAUSTED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE
  } state_e;

  typedef struct packed {
    logic                  hit;
    logic [WORD_SHIFT-1:0] pos;
  } zero_pos_t;

  function automatic zero_pos_t lowest_zero(logic [WORD_BITS-1:0] w);
    zero_pos_t r;
    r.hit = 1'b0;
    r.pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r.hit = 1'b1;
        r.pos = WORD_SHIFT'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: src/fba_bitmap_mem.sv
module fba_bitmap_mem #(
  parameter int unsigned WORDS = fba_pkg::MAX_FRAMES_DEF / fba_pkg::WORD_BITS,
  parameter int unsigned AW    = 7
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [fba_pkg::WORD_BITS-1:0] wdata_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [fba_pkg::WORD_BITS-1:0] rdata_o
);

  logic [fba_pkg::WORD_BITS-1:0] mem_q [WORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: src/frame_bitmap_allocator_unit.sv
// Channel  | Ports                                              | Handshake
// ---------+----------------------------------------------------+-------------------------
// request  | op_i, current_frame_i, is_kernel_i, is_writable_i  | start high, busy low
// result   | frame_number_o, present_o, writable_o,            | done_o, one cycle, no stall
//          | user_access_o, status_o                            |
// config   | psel, penable, pwrite, paddr, pwdata, prdata       | APB write, pready tied high
//
// done_o rises in the cycle busy falls back low, or the cycle after accept if busy stays low.
// Held, nothing-to-free, out-of-range free and zero frame_count: busy stays low.
// Free: one bitmap read at accept, then one write back in S_FREE.
// Alloc: one bitmap word read per cycle over the first ceil(min(frame_count, MAX_FRAMES)/32) words.
// After reset the bitmap is cleared one word a cycle, all ceil(MAX_FRAMES/32) words (128 by default),
// with busy high. The receiver cannot stall; done_o is a single-cycle strobe.
`include "frame_bitmap_allocator_unit_macros.svh"

module frame_bitmap_allocator_unit #(
  parameter int unsigned MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fba_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic [fba_pkg::FRAME_W-1:0]   current_frame_i,
  input  logic                          is_kernel_i,
  input  logic                          is_writable_i,
  output logic                          done_o,
  output logic [fba_pkg::FRAME_W-1:0]   frame_number_o,
  output logic                          present_o,
  output logic                          writable_o,
  output logic                          user_access_o,
  output logic [fba_pkg::STATUS_W-1:0]  status_o
);

  localparam int unsigned WORDS = (MAX_FRAMES + fba_pkg::WORD_BITS - 1) / fba_pkg::WORD_BITS;
  localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned WB    = fba_pkg::WORD_BITS;
  localparam int unsigned CW    = fba_pkg::CNT_W;
  localparam int unsigned FW    = fba_pkg::FRAME_W;

  fba_pkg::state_e  state_q, state_d;
  logic [WAW-1:0]   scan_q, scan_d;
  logic [WAW-1:0]   eval_q, eval_d;
  logic             rdv_q, rdv_d;
  logic [WAW-1:0]   clr_q, clr_d;
  logic [CW-1:0]    frame_count_q;
  logic [FW-1:0]    cur_q;
  logic             wr_q;
  logic             kern_q;

  logic             done_q, done_d;
  logic [FW-1:0]    fnum_q, fnum_d;
  logic             pres_q, pres_d;
  logic             wflag_q, wflag_d;
  logic             uflag_q, uflag_d;
  fba_pkg::status_e status_q, status_d;

  logic             mem_we;
  logic [WAW-1:0]   mem_waddr;
  logic [WB-1:0]    mem_wdata;
  logic             mem_re;
  logic [WAW-1:0]   mem_raddr;
  logic [WB-1:0]    mem_rdata;

  logic             accept;
  logic             cfg_write;
  logic             cur_in_range;
  logic [CW-1:0]    lim;
  logic [WAW-1:0]   last_w;
  logic [WB-1:0]    pad_mask;
  logic [WB-1:0]    padded;
  logic [FW-1:0]    found;
  fba_pkg::zero_pos_t zp;

  logic             held_req;
  logic             held_done;
  logic             free_req;
  logic             free_done;
  logic             alloc_done;
  logic             alloc_in_lim;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[2] == fba_pkg::REG_FRAME_COUNT) ? 32'(frame_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= fba_pkg::FRAME_COUNT_RST;
    end else if (cfg_write && paddr[2] == fba_pkg::REG_FRAME_COUNT) begin
      frame_count_q <= pwdata[CW-1:0];
    end
  end

  assign lim = (32'(frame_count_q) > MAX_FRAMES) ? CW'(MAX_FRAMES) : frame_count_q;
  assign last_w = WAW'((lim - CW'(1)) >> fba_pkg::WORD_SHIFT);
  assign cur_in_range = 32'(current_frame_i) < MAX_FRAMES;
  assign accept = start && (state_q == fba_pkg::S_IDLE);
  assign busy = (state_q != fba_pkg::S_IDLE);

  // force bits at or above the limit to look used
  assign pad_mask = (eval_q == last_w && lim[fba_pkg::WORD_SHIFT-1:0] != '0)
                  ? ~((WB'(1) << lim[fba_pkg::WORD_SHIFT-1:0]) - WB'(1)) : '0;
  assign padded = mem_rdata | pad_mask;
  assign zp     = fba_pkg::lowest_zero(padded);
  assign found  = FW'({eval_q, zp.pos});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fba_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    scan_d    = scan_q;
    eval_d    = eval_q;
    rdv_d     = 1'b0;
    clr_d     = clr_q;
    mem_we    = 1'b0;
    mem_waddr = eval_q;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = scan_q;
    done_d    = 1'b0;
    fnum_d    = fnum_q;
    pres_d    = pres_q;
    wflag_d   = wflag_q;
    uflag_d   = uflag_q;
    status_d  = status_q;
    case (state_q)
      fba_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + WAW'(1);
        if (clr_q == WAW'(WORDS - 1)) begin
          state_d = fba_pkg::S_IDLE;
        end
      end
      fba_pkg::S_IDLE: begin
        if (accept) begin
          fnum_d  = '0;
          pres_d  = 1'b0;
          wflag_d = 1'b0;
          uflag_d = 1'b0;
          if (op_i == fba_pkg::OP_ALLOC) begin
            if (current_frame_i != '0) begin
              done_d   = 1'b1;
              fnum_d   = current_frame_i;
              status_d = fba_pkg::ST_HELD;
            end else if (lim == '0) begin
              done_d   = 1'b1;
              status_d = fba_pkg::ST_EXHAUSTED;
            end else begin
              scan_d  = '0;
              state_d = fba_pkg::S_SCAN;
            end
          end else begin
            if (current_frame_i == '0) begin
              done_d   = 1'b1;
              status_d = fba_pkg::ST_NOTHING;
            end else if (cur_in_range) begin
              mem_re    = 1'b1;
              mem_raddr = WAW'(current_frame_i >> fba_pkg::WORD_SHIFT);
              state_d   = fba_pkg::S_FREE;
            end else begin
              done_d   = 1'b1;
              status_d = fba_pkg::ST_FREED;
            end
          end
        end
      end
      fba_pkg::S_FREE: begin
        mem_we    = 1'b1;
        mem_waddr = WAW'(cur_q >> fba_pkg::WORD_SHIFT);
        mem_wdata = mem_rdata & ~(WB'(1) << cur_q[fba_pkg::WORD_SHIFT-1:0]);
        done_d    = 1'b1;
        status_d  = fba_pkg::ST_FREED;
        state_d   = fba_pkg::S_IDLE;
      end
      fba_pkg::S_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = scan_q;
        eval_d    = scan_q;
        rdv_d     = 1'b1;
        if (scan_q != last_w) begin
          scan_d = scan_q + WAW'(1);
        end
        if (rdv_q) begin
          if (zp.hit) begin
            mem_we    = 1'b1;
            mem_waddr = eval_q;
            mem_wdata = mem_rdata | (WB'(1) << zp.pos);
            done_d    = 1'b1;
            fnum_d    = found;
            pres_d    = 1'b1;
            wflag_d   = wr_q;
            uflag_d   = ~kern_q;
            status_d  = fba_pkg::ST_ALLOCATED;
            state_d   = fba_pkg::S_IDLE;
          end else if (eval_q == last_w) begin
            done_d   = 1'b1;
            status_d = fba_pkg::ST_EXHAUSTED;
            state_d  = fba_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = fba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      eval_q <= '0;
      rdv_q  <= 1'b0;
      clr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      scan_q <= scan_d;
      eval_q <= eval_d;
      rdv_q  <= rdv_d;
      clr_q  <= clr_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fnum_q   <= fnum_d;
    pres_q   <= pres_d;
    wflag_q  <= wflag_d;
    uflag_q  <= uflag_d;
    status_q <= status_d;
    if (accept) begin
      cur_q  <= current_frame_i;
      wr_q   <= is_writable_i;
      kern_q <= is_kernel_i;
    end
  end

  fba_bitmap_mem #(
    .WORDS (WORDS),
    .AW    (WAW)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign done_o         = done_q;
  assign frame_number_o = fnum_q;
  assign present_o      = pres_q;
  assign writable_o     = wflag_q;
  assign user_access_o  = uflag_q;
  assign status_o       = status_q;

  assign held_req     = accept && op_i == fba_pkg::OP_ALLOC && current_frame_i != '0;
  assign held_done    = done_o && status_o == fba_pkg::ST_HELD && frame_number_o == cur_q;
  assign free_req     = accept && op_i == fba_pkg::OP_FREE && current_frame_i != '0
                        && cur_in_range;
  assign free_done    = done_o && status_o == fba_pkg::ST_FREED;
  assign alloc_done   = done_o && status_o == fba_pkg::ST_ALLOCATED;
  assign alloc_in_lim = ({1'b0, frame_number_o} < lim) && present_o;

  `FBA_ASSERT_NEXT(a_held_echo, held_req, held_done, "held entry not echoed")
  `FBA_ASSERT(a_free_two, free_req |-> ##2 free_done, "free result late")
  `FBA_ASSERT(a_clear_quiet, (state_q == fba_pkg::S_CLEAR) |-> (!done_o && busy), "clear busy")
  `FBA_ASSERT(a_alloc_limit, alloc_done |-> alloc_in_lim, "allocated frame beyond limit")

endmodule

// File: bench/frame_bitmap_allocator_checker.sv
module frame_bitmap_allocator_checker
  import fba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [ADDR_W-1:0]   paddr_i,
  input  logic [31:0]         pwdata_i,
  input  logic [31:0]         prdata_i,
  input  logic                pready_i,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic                op_i,
  input  logic [FRAME_W-1:0]  current_frame_i,
  input  logic                is_kernel_i,
  input  logic                is_writable_i,
  input  logic                done_i,
  input  logic [FRAME_W-1:0]  frame_number_i,
  input  logic                present_i,
  input  logic                writable_i,
  input  logic                user_access_i,
  input  logic [STATUS_W-1:0] status_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  typedef struct {
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               writable;
    logic               user;
    status_e            status;
  } grant_t;

  logic [MAX_FRAMES_DEF-1:0] used_frames;
  logic [CNT_W-1:0]          frame_limit;
  grant_t                    grants_due[$];
  int                        mismatches = 0;

  assign mismatches_o = mismatches;

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic grant_t settle_request(op_e op, logic [FRAME_W-1:0] cur,
                                            logic kern, logic wr);
    grant_t      g;
    int unsigned lim;
    int unsigned f;
    g = '{frame: '0, present: 1'b0, writable: 1'b0, user: 1'b0, status: ST_NOTHING};
    if (op == OP_ALLOC) begin
      if (cur != '0) begin
        g.frame  = cur;
        g.status = ST_HELD;
      end else begin
        lim = (32'(frame_limit) > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : 32'(frame_limit);
        f = 0;
        while (f < lim && used_frames[FRAME_W'(f)]) f++;
        if (f < lim) begin
          used_frames[FRAME_W'(f)] = 1'b1;
          g.frame    = FRAME_W'(f);
          g.present  = 1'b1;
          g.writable = wr;
          g.user     = ~kern;
          g.status   = ST_ALLOCATED;
        end else begin
          g.status = ST_EXHAUSTED;
        end
      end
    end else if (cur != '0) begin
      used_frames[cur] = 1'b0;
      g.status = ST_FREED;
    end
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      used_frames = '0;
      frame_limit = FRAME_COUNT_RST;
      grants_due.delete();
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (grants_due.size() == 0) begin
          note_mismatch("result word with none pending", 32'(frame_number_i), '0);
        end else begin
          want = grants_due.pop_front();
          if (frame_number_i !== want.frame)
            note_mismatch("frame_number", 32'(frame_number_i), 32'(want.frame));
          if (present_i !== want.present)
            note_mismatch("present", 32'(present_i), 32'(want.present));
          if (writable_i !== want.writable)
            note_mismatch("writable", 32'(writable_i), 32'(want.writable));
          if (user_access_i !== want.user)
            note_mismatch("user_access", 32'(user_access_i), 32'(want.user));
          if (status_i !== want.status)
            note_mismatch("status", 32'(status_i), 32'(want.status));
        end
      end
      if (psel_i && penable_i && pready_i && paddr_i[ADDR_W-1:2] == REG_FRAME_COUNT) begin
        if (pwrite_i)
          frame_limit = pwdata_i[CNT_W-1:0];
        else if (prdata_i !== 32'(frame_limit))
          note_mismatch("frame_count readback", prdata_i, 32'(frame_limit));
      end
      if (start_i && !busy_i)
        grants_due.push_back(settle_request(op_e'(op_i), current_frame_i,
                                            is_kernel_i, is_writable_i));
      pending_o <= grants_due.size();
    end
  end

endmodule

// File: bench/tb_frame_bitmap_allocator_unit.sv
module tb_frame_bitmap_allocator_unit;
  import fba_pkg::*;

  localparam int                BATCH_ITEMS = 138;
  localparam int                STALL_LIMIT = 2000;
  localparam logic [ADDR_W-1:0] FC_ADDR     = {REG_FRAME_COUNT, 2'b00};
  localparam logic [ADDR_W-1:0] SPARE_ADDR  = {~REG_FRAME_COUNT, 2'b00};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                start = 1'b0;
  logic                busy;
  op_e                 req_op = OP_ALLOC;
  logic [FRAME_W-1:0]  req_frame = '0;
  logic                req_kernel = 1'b0;
  logic                req_writable = 1'b0;
  logic                done;
  logic [FRAME_W-1:0]  frame_number;
  logic                present;
  logic                writable;
  logic                user_access;
  logic [STATUS_W-1:0] status;
  int                  mismatches;
  int                  pending;

  int                  idle_pct = 0;
  int                  sent = 0;
  int                  settings = 0;
  int                  stall_cycles = 0;
  int unsigned         count_plan [12] = '{4096, 37, 0, 8191, 1, 100, 33, 4096,
                                           64, 31, 5000, 200};
  int                  idle_plan [3] = '{14, 54, 0};

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  frame_bitmap_allocator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .start           (start),
    .busy            (busy),
    .op_i            (req_op),
    .current_frame_i (req_frame),
    .is_kernel_i     (req_kernel),
    .is_writable_i   (req_writable),
    .done_o          (done),
    .frame_number_o  (frame_number),
    .present_o       (present),
    .writable_o      (writable),
    .user_access_o   (user_access),
    .status_o        (status)
  );

  frame_bitmap_allocator_checker grant_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_i        (prdata),
    .pready_i        (pready),
    .start_i         (start),
    .busy_i          (busy),
    .op_i            (req_op),
    .current_frame_i (req_frame),
    .is_kernel_i     (req_kernel),
    .is_writable_i   (req_writable),
    .done_i          (done),
    .frame_number_i  (frame_number),
    .present_i       (present),
    .writable_i      (writable),
    .user_access_i   (user_access),
    .status_i        (status),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send(op_e op, logic [FRAME_W-1:0] cur, logic kern, logic wr);
    int gap;
    start        <= 1'b1;
    req_op       <= op;
    req_frame    <= cur;
    req_kernel   <= kern;
    req_writable <= wr;
    do @(posedge clk_i); while (busy);
    sent++;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold the request side until every pending word is back
  task automatic await_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (busy || pending != 0);
  endtask

  task automatic cfg_access(logic wr, logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (wr && addr == FC_ADDR) settings++;
  endtask

  task automatic random_request(int unsigned eff);
    int unsigned r;
    int unsigned hi;
    r  = $urandom_range(99);
    hi = (eff < 160) ? eff + 4 : 160;
    if (r < 50)
      send(OP_ALLOC, '0, 1'($urandom_range(1)), 1'($urandom_range(1)));
    else if (r < 80)
      send(OP_FREE, FRAME_W'($urandom_range(hi)), 1'($urandom_range(1)),
           1'($urandom_range(1)));
    else if (r < 90)
      send(OP_ALLOC, FRAME_W'($urandom_range(4095, 1)), 1'($urandom_range(1)),
           1'($urandom_range(1)));
    else
      send(OP_FREE, FRAME_W'($urandom()), 1'($urandom_range(1)),
           1'($urandom_range(1)));
  endtask

  task automatic run_batch(int unsigned count, int pct);
    int unsigned eff;
    eff = (count > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : count;
    await_idle();
    cfg_access(1'b1, FC_ADDR, ($urandom() & 32'hFFFF_E000) | count);
    cfg_access(1'b0, FC_ADDR, '0);
    idle_pct = pct;
    for (int i = 0; i < BATCH_ITEMS; i++) begin
      if (i == BATCH_ITEMS / 2) await_idle();
      random_request(eff);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    await_idle();

    cfg_access(1'b0, FC_ADDR, '0);
    send(OP_ALLOC, '0, 1'b0, 1'b1);
    send(OP_ALLOC, '0, 1'b1, 1'b0);
    send(OP_ALLOC, '0, 1'b1, 1'b1);
    send(OP_ALLOC, 12'hFFF, 1'b1, 1'b1);
    send(OP_ALLOC, 12'h001, 1'b0, 1'b0);
    send(OP_FREE, '0, 1'b1, 1'b1);
    send(OP_FREE, 12'h001, 1'b0, 1'b0);
    send(OP_ALLOC, '0, 1'b0, 1'b0);
    send(OP_FREE, 12'hFFF, 1'b0, 1'b0);
    send(OP_FREE, 12'hAAA, 1'b1, 1'b0);
    await_idle();
    cfg_access(1'b1, SPARE_ADDR, '0);
    cfg_access(1'b0, FC_ADDR, '0);

    cfg_access(1'b1, FC_ADDR, 32'd0);
    send(OP_ALLOC, '0, 1'b0, 1'b1);
    send(OP_FREE, 12'd4000, 1'b0, 1'b0);
    await_idle();
    cfg_access(1'b1, FC_ADDR, 32'd2);
    send(OP_ALLOC, '0, 1'b0, 1'b1);
    send(OP_FREE, 12'h001, 1'b0, 1'b0);
    send(OP_ALLOC, '0, 1'b1, 1'b1);
    send(OP_ALLOC, '0, 1'b0, 1'b0);
    await_idle();
    cfg_access(1'b1, FC_ADDR, 32'h0000_1FFF);
    cfg_access(1'b0, FC_ADDR, '0);
    send(OP_ALLOC, '0, 1'b1, 1'b0);
    send(OP_ALLOC, 12'h555, 1'b0, 1'b1);
    send(OP_ALLOC, '0, 1'b0, 1'b1);

    for (int b = 0; b < 12; b++) run_batch(count_plan[b], idle_plan[b / 4]);

    await_idle();
    repeat (200) @(posedge clk_i);

    $display("Covered %0d requests under %0d frame_count settings (0 to 8191),",
             sent, settings);
    $display("with request gaps at 14, 54 and 0 percent and drained pauses mid-batch.");
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/fba_pkg.sv
src/fba_bitmap_mem.sv
src/frame_bitmap_allocator_unit.sv
bench/frame_bitmap_allocator_checker.sv
bench/tb_frame_bitmap_allocator_unit.sv
